// ===== src/chist_pkg.sv =====
// Shared constants, codes and control types of the clipped sample histogram.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package chist_pkg;

   localparam int unsigned BINS             = 256;
   localparam int unsigned BIN_BITS         = 8;
   localparam int unsigned COUNT_LIMIT_BITS = 24;
   localparam int unsigned DATA_W           = 32;
   localparam int unsigned NORM_W           = 17;
   localparam int unsigned COUNT_W          = 25;
   localparam int unsigned OP_W             = 2;
   localparam int unsigned REQ_W            = 40;
   localparam int unsigned RSP_W            = 72;

   localparam logic [NORM_W-1:0]   NORM_ONE    = 17'h10000;
   localparam logic [BIN_BITS-1:0] BIN_MAX     = 8'hFF;
   localparam logic [DATA_W-1:0]   CLIP_RESET  = 32'h0000_0000;
   localparam logic [DATA_W-1:0]   SCALE_RESET = 32'h00FF_0000;

   // Configuration register indexes.
   localparam logic CSR_CLIP_LOW  = 1'b0;
   localparam logic CSR_BIN_SCALE = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DIFF   = 9'b000000010,
      ST_MULT   = 9'b000000100,
      ST_ADDR   = 9'b000001000,
      ST_UPD    = 9'b000010000,
      ST_DSTART = 9'b000100000,
      ST_DWAIT  = 9'b001000000,
      ST_RESP   = 9'b010000000,
      ST_CLR    = 9'b100000000
   } state_type;

   typedef struct packed {
      logic load_in;
      logic calc_diff;
      logic calc_prod;
      logic mem_rd;
      logic sel_index;
      logic update;
      logic write_back;
      logic div_start;
      logic load_out;
      logic use_quot;
      logic clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic peak_zero;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

// ===== src/chist_div.sv =====
// Restoring divider, one quotient bit per cycle, for the bin normalization.
// Depends on chist_pkg for nothing but sits beside the datapath that uses it.
`timescale 1ns / 1ps

module chist_div #(
   parameter int unsigned CW = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CW+15:0]     dividend,
   input  logic [CW-1:0]      divisor,
   output logic               busy,
   output logic [CW+15:0]     quotient
);

   localparam int unsigned DW    = CW + 16;
   localparam int unsigned CNT_W = $clog2(DW + 1);

   logic [CW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [CW-1:0]    dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   logic [CW:0] shifted;
   logic [CW:0] sub;
   logic        fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      sub     = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? sub[CW-1:0] : shifted[CW-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/chist_ctrl.sv =====
// Controller state machine of the clipped sample histogram.
// Uses chist_pkg for the state, opcode and command/status types.
`timescale 1ns / 1ps

module chist_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [chist_pkg::OP_W-1:0]    req_tuser,
   input  logic                          req_tlast,
   input  chist_pkg::dp_status_type      sts,
   output chist_pkg::ctrl_cmd_type       cmd
);

   chist_pkg::state_type           state_ff, state_in;
   logic [chist_pkg::OP_W-1:0]     op_ff, op_in;
   logic                           last_ff, last_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      last_in  = last_ff;
      cmd      = '0;
      case (state_ff)
         chist_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               op_in       = req_tuser;
               last_in     = req_tlast;
               case (req_tuser)
                  chist_pkg::OP_ADD:   state_in = chist_pkg::ST_DIFF;
                  chist_pkg::OP_READ:  state_in = chist_pkg::ST_ADDR;
                  chist_pkg::OP_CLEAR: state_in = chist_pkg::ST_CLR;
                  default:             state_in = chist_pkg::ST_IDLE;
               endcase
            end
         end
         chist_pkg::ST_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = chist_pkg::ST_MULT;
         end
         chist_pkg::ST_MULT: begin
            cmd.calc_prod = 1'b1;
            state_in      = chist_pkg::ST_ADDR;
         end
         chist_pkg::ST_ADDR: begin
            cmd.mem_rd    = 1'b1;
            cmd.sel_index = (op_ff == chist_pkg::OP_READ);
            state_in      = chist_pkg::ST_UPD;
         end
         chist_pkg::ST_UPD: begin
            cmd.update = 1'b1;
            if (op_ff == chist_pkg::OP_ADD) begin
               cmd.write_back = 1'b1;
               state_in = last_ff ? chist_pkg::ST_RESP : chist_pkg::ST_IDLE;
            end else begin
               state_in = sts.peak_zero ? chist_pkg::ST_RESP : chist_pkg::ST_DSTART;
            end
         end
         chist_pkg::ST_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = chist_pkg::ST_DWAIT;
         end
         chist_pkg::ST_DWAIT: begin
            if (sts.div_done) begin
               state_in = chist_pkg::ST_RESP;
            end
         end
         chist_pkg::ST_RESP: begin
            // Wait here only while the previous word still sits in the output register.
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.use_quot = (op_ff == chist_pkg::OP_READ) && !sts.peak_zero;
               state_in     = chist_pkg::ST_IDLE;
            end
         end
         chist_pkg::ST_CLR: begin
            cmd.clear = 1'b1;
            state_in  = chist_pkg::ST_IDLE;
         end
         default: begin
            state_in = chist_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chist_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      last_ff <= last_in;
   end

   assign req_tready = (state_ff == chist_pkg::ST_IDLE);

endmodule

// ===== src/chist_dp.sv =====
// Datapath of the clipped sample histogram: bin mapping, count store, peak,
// divider and output register. Uses chist_pkg and instantiates chist_div.
`timescale 1ns / 1ps

module chist_dp #(
   parameter int unsigned COUNT_LIMIT_BITS = chist_pkg::COUNT_LIMIT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [chist_pkg::REQ_W-1:0]       req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [chist_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                              csr_valid,
   input  logic                              csr_index,
   input  logic [chist_pkg::DATA_W-1:0]      csr_data,
   input  chist_pkg::ctrl_cmd_type           cmd,
   output chist_pkg::dp_status_type          sts
);

   localparam int unsigned CW  = COUNT_LIMIT_BITS + 1;
   localparam int unsigned DW  = CW + 16;
   localparam int unsigned BB  = chist_pkg::BIN_BITS;
   localparam int unsigned NW  = chist_pkg::NORM_W;
   localparam int unsigned KW  = chist_pkg::COUNT_W;
   localparam logic [CW-1:0] LIMIT = {1'b1, {COUNT_LIMIT_BITS{1'b0}}};

   // Configuration registers.
   logic [31:0] clip_low_ff, scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_low_ff <= chist_pkg::CLIP_RESET;
         scale_ff    <= chist_pkg::SCALE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            chist_pkg::CSR_CLIP_LOW:  clip_low_ff <= csr_data;
            chist_pkg::CSR_BIN_SCALE: scale_ff    <= csr_data;
            default:                  clip_low_ff <= clip_low_ff;
         endcase
      end
   end

   // Bin mapping: difference, product, then rounding and clamping.
   logic [31:0]   sample_ff;
   logic [BB-1:0] index_ff;
   logic [32:0]   diff_ff;
   logic [63:0]   prod_ff;
   logic          pos_ff;
   logic [64:0]   rnd;
   logic [32:0]   hi;
   logic [BB-1:0] bin_map, addr, addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         sample_ff <= req_tdata[31:0];
         index_ff  <= req_tdata[39:32];
      end
      if (cmd.calc_diff) begin
         diff_ff <= {sample_ff[31], sample_ff} - {clip_low_ff[31], clip_low_ff};
      end
      if (cmd.calc_prod) begin
         prod_ff <= diff_ff[31:0] * scale_ff;
         pos_ff  <= !diff_ff[32] && (diff_ff != 33'd0);
      end
      if (cmd.mem_rd) begin
         addr_ff <= addr;
      end
   end

   always_comb begin
      rnd = {1'b0, prod_ff} + 65'h0_8000_0000;
      hi  = rnd[64:32];
      if (!pos_ff) begin
         bin_map = '0;
      end else if (hi > 33'd255) begin
         bin_map = chist_pkg::BIN_MAX;
      end else begin
         bin_map = hi[BB-1:0];
      end
      addr = cmd.sel_index ? index_ff : bin_map;
   end

   // Count store; a bin whose valid bit is clear reads as zero.
   logic [CW-1:0]        mem [chist_pkg::BINS];
   logic [chist_pkg::BINS-1:0] vld_ff;
   logic [CW-1:0]        rd_q_ff;
   logic                 vld_q_ff;
   logic [CW-1:0]        cnt_old, cnt_new, cnt_ff, peak_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_q_ff  <= mem[addr];
         vld_q_ff <= vld_ff[addr];
      end
      if (cmd.write_back) begin
         mem[addr_ff] <= cnt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         vld_ff  <= '0;
         peak_ff <= '0;
      end else if (cmd.write_back) begin
         vld_ff[addr_ff] <= 1'b1;
         if (cnt_new > peak_ff) begin
            peak_ff <= cnt_new;
         end
      end
   end

   always_comb begin
      cnt_old = vld_q_ff ? rd_q_ff : '0;
      cnt_new = (cnt_old < LIMIT) ? cnt_old + 1'b1 : cnt_old;
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         cnt_ff <= cmd.write_back ? cnt_new : cnt_old;
      end
   end

   // Normalization: (count * 2^16 + peak / 2) / peak, saturated at 1.0.
   logic [DW-1:0] dividend, quotient;
   logic          div_busy;
   logic [NW-1:0] norm;

   assign dividend = {cnt_ff, 16'h0000} + {17'd0, peak_ff[CW-1:1]};

   chist_div #(
      .CW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (peak_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign norm = (quotient > {{(DW-NW){1'b0}}, chist_pkg::NORM_ONE}) ?
                 chist_pkg::NORM_ONE : quotient[NW-1:0];

   // Output register.
   logic [CW+KW-1:0] cnt_wide, peak_wide;
   logic             out_full_ff, out_full_in;
   logic [NW-1:0]    norm_ff;
   logic [KW-1:0]    cnt_out_ff, peak_out_ff;
   logic             empty_ff;

   assign cnt_wide  = {{KW{1'b0}}, cnt_ff};
   assign peak_wide = {{KW{1'b0}}, peak_ff};

   always_comb begin
      out_full_in = out_full_ff;
      if (cmd.load_out) begin
         out_full_in = 1'b1;
      end else if (rsp_tready) begin
         out_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else begin
         out_full_ff <= out_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         norm_ff     <= cmd.use_quot ? norm : '0;
         cnt_out_ff  <= cnt_wide[KW-1:0];
         peak_out_ff <= peak_wide[KW-1:0];
         empty_ff    <= (peak_ff == '0);
      end
   end

   assign rsp_tvalid = out_full_ff;
   assign rsp_tdata  = {4'h0, empty_ff, peak_out_ff, cnt_out_ff, norm_ff};

   assign sts.peak_zero = (peak_ff == '0);
   assign sts.div_done  = !div_busy;
   assign sts.out_free  = !out_full_ff || rsp_tready;

endmodule

// ===== src/clipped_sample_histogram.sv =====
// Clipped sample histogram: 256 saturating bin counts with a running peak.
// Add sample: accept, difference, multiply, read, update (and respond if last); one word at a time.
// Read bin: accept, read, update, divide one bit per cycle if the peak is nonzero, respond.
// Clear: accept, then clear. A result sits in an output register until taken.
// Synchronous active-high reset zeroes the peak and, through per-bin valid bits, all counts
// at once, and loads clip_low = 0 and bin_scale = 0x00FF0000 (255/2^16 as a 0.32 fraction).
`timescale 1ns / 1ps

module clipped_sample_histogram #(
   parameter int unsigned COUNT_LIMIT_BITS = chist_pkg::COUNT_LIMIT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [chist_pkg::REQ_W-1:0]   req_tdata,   // sample[31:0], bin_index[39:32]
   input  logic [chist_pkg::OP_W-1:0]    req_tuser,   // opcode[1:0]
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [chist_pkg::RSP_W-1:0]   rsp_tdata,   // normalized_value[16:0],
                                                      // bin_count[41:17],
                                                      // peak_count[66:42],
                                                      // empty_set[67], zero[71:68]
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [chist_pkg::DATA_W-1:0]  csr_data
);

   chist_pkg::ctrl_cmd_type  cmd;
   chist_pkg::dp_status_type sts;

   assign csr_ready = 1'b1;

   chist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .sts        (sts),
      .cmd        (cmd)
   );

   chist_dp #(
      .COUNT_LIMIT_BITS (COUNT_LIMIT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts)
   );

   // A clear word leaves the peak at zero once the clear step is done.
   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == chist_pkg::OP_CLEAR) |-> ##2 sts.peak_zero)
      else $error("peak not zero after clear");

   // Loading the output register always presents a word.
   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid)
      else $error("loaded result not presented");

   // An empty set carries a zero normalized value.
   a_empty_norm : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[67]) |-> (rsp_tdata[16:0] == '0))
      else $error("normalized value nonzero for empty set");

   // The normalized value never exceeds 1.0.
   a_norm_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[16:0] <= chist_pkg::NORM_ONE))
      else $error("normalized value above 1.0");

endmodule
